/* rtl/core/gmms_pkg.sv */
// shared types and constants of the grouped min/max/mean statistics block
// no dependencies; imported by every module of the block
`default_nettype none

package gmms_pkg;

   // fixed field widths of the record and result transactions
   localparam int GROUP_W   = 4;
   localparam int TEMP_W    = 8;

   // quotient bits of the mean divider (the mean always fits in 8 bits)
   localparam int MEAN_BITS = 8;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // classified record as it travels through the queue
   typedef struct packed {
      logic                     hit;
      logic [GROUP_W-1:0]       index;
      logic signed [TEMP_W-1:0] temperature;
      logic                     is_last;
   } cmd_type;

   // back end sequencer
   typedef enum logic [2:0] {
      ST_FETCH,
      ST_UPDATE,
      ST_RPT_READ,
      ST_RPT_START,
      ST_RPT_WAIT,
      ST_TOT_START,
      ST_TOT_WAIT
   } back_state_type;

endpackage

`default_nettype wire

/* rtl/core/gmms_front.sv */
// front end: accepts record transactions, classifies the group, queues them
// depends on gmms_pkg
`default_nettype none

module gmms_front #(
   parameter int NUM_GROUPS = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [gmms_pkg::GROUP_W-1:0]      req_group,
   input  wire logic signed [gmms_pkg::TEMP_W-1:0] req_temperature,
   input  wire logic                              req_is_last,
   output logic                                   q_valid,
   output gmms_pkg::cmd_type                      q_cmd,
   input  wire logic                              q_pop
);
   import gmms_pkg::*;

   cmd_type                fifo_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]        count_ff, count_in;
   logic                   push;
   cmd_type                cmd;

   // classification: only groups 1..NUM_GROUPS are accumulated
   always_comb begin
      cmd.hit         = (req_group != '0) && (7'(req_group) <= 7'(NUM_GROUPS));
      cmd.index       = req_group - GROUP_W'(1);
      cmd.temperature = req_temperature;
      cmd.is_last     = req_is_last;
   end

   assign req_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = fifo_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/gmms_div.sv */
// iterative signed-by-unsigned divider for the mean, one quotient bit a cycle
// depends on gmms_pkg; quotient magnitude must stay below 2**MEAN_BITS
`default_nettype none

module gmms_div #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 24
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0]        divisor,
   output logic                         busy,
   output logic signed [gmms_pkg::MEAN_BITS-1:0] quotient
);
   import gmms_pkg::*;

   localparam int SH_W   = DEN_W + MEAN_BITS - 1;
   localparam int STEP_W = $clog2(MEAN_BITS);

   logic                   busy_ff, busy_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   neg_ff, neg_in;
   logic [NUM_W-1:0]       rem_ff, rem_in;
   logic [SH_W-1:0]        dsh_ff, dsh_in;
   logic [MEAN_BITS-1:0]   q_ff, q_in;
   logic [NUM_W-1:0]       mag;
   logic [NUM_W-1:0]       dsh_ext;
   logic                   ge;

   assign mag     = dividend[NUM_W-1] ? (NUM_W'(~dividend) + NUM_W'(1)) : NUM_W'(dividend);
   assign dsh_ext = NUM_W'(dsh_ff);
   assign ge      = (rem_ff >= dsh_ext);

   // restoring step against the shifted divisor
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(MEAN_BITS - 1);
         neg_in  = dividend[NUM_W-1];
         rem_in  = mag;
         dsh_in  = {divisor, {(MEAN_BITS-1){1'b0}}};
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_ff - dsh_ext : rem_ff;
         dsh_in = dsh_ff >> 1;
         q_in   = {q_ff[MEAN_BITS-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? $signed(~q_ff + MEAN_BITS'(1)) : $signed(q_ff);

endmodule

`default_nettype wire

/* rtl/core/gmms_back.sv */
// back end: per-group store, read-modify-write of records, report sequencer
// depends on gmms_pkg and gmms_div
`default_nettype none

module gmms_back #(
   parameter int NUM_GROUPS = 12,
   parameter int COUNT_BITS = 20
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               q_valid,
   input  wire gmms_pkg::cmd_type                  q_cmd,
   output logic                                    q_pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [gmms_pkg::GROUP_W-1:0]            rsp_group_id,
   output logic [COUNT_BITS-1:0]                   rsp_record_count,
   output logic signed [gmms_pkg::TEMP_W-1:0]      rsp_min_value,
   output logic signed [gmms_pkg::TEMP_W-1:0]      rsp_max_value,
   output logic signed [gmms_pkg::MEAN_BITS-1:0]   rsp_mean_value,
   output logic                                    rsp_last_result
);
   import gmms_pkg::*;

   localparam int IDX_W    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int SUM_BITS = COUNT_BITS + TEMP_W;
   localparam int TSUM_W   = SUM_BITS + IDX_W;
   localparam int TCNT_W   = COUNT_BITS + IDX_W;

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff;
   logic [IDX_W-1:0] rpt_idx_ff, rpt_idx_in;

   // group store
   logic [COUNT_BITS-1:0]      cnt_mem [NUM_GROUPS];
   logic signed [SUM_BITS-1:0] sum_mem [NUM_GROUPS];
   logic signed [TEMP_W-1:0]   min_mem [NUM_GROUPS];
   logic signed [TEMP_W-1:0]   max_mem [NUM_GROUPS];
   logic [NUM_GROUPS-1:0]      valid_ff;

   logic                       rd_en, wr_en, clr_valid;
   logic [IDX_W-1:0]           rd_addr, q_addr, cmd_addr;
   logic [IDX_W+GROUP_W-1:0]   q_wide, cmd_wide, id_wide;
   logic [COUNT_BITS-1:0]      rd_cnt_ff;
   logic signed [SUM_BITS-1:0] rd_sum_ff;
   logic signed [TEMP_W-1:0]   rd_min_ff, rd_max_ff;
   logic                       rd_valid_ff;

   logic [COUNT_BITS-1:0]      ent_cnt, new_cnt;
   logic signed [SUM_BITS-1:0] ent_sum, new_sum;
   logic signed [TEMP_W-1:0]   ent_min, ent_max, new_min, new_max;
   logic                       ent_empty, cnt_sat;

   // report totals
   logic [TCNT_W-1:0]          tot_cnt_ff;
   logic signed [TSUM_W-1:0]   tot_sum_ff;
   logic signed [TEMP_W-1:0]   tot_min_ff, tot_max_ff;
   logic                       seen_ff;
   logic                       tot_clr, tot_acc;

   // divider
   logic                       div_start, div_busy;
   logic signed [TSUM_W-1:0]   div_num;
   logic [TCNT_W-1:0]          div_den;
   logic signed [MEAN_BITS-1:0] div_q;

   // output register
   logic                       out_free, load_grp, load_tot;
   logic                       rsp_valid_ff;
   logic [GROUP_W-1:0]         rsp_group_ff;
   logic [COUNT_BITS-1:0]      rsp_count_ff;
   logic signed [TEMP_W-1:0]   rsp_min_ff, rsp_max_ff;
   logic signed [MEAN_BITS-1:0] rsp_mean_ff;
   logic                       rsp_last_ff;

   // group index to store address
   assign q_wide   = {{IDX_W{1'b0}}, q_cmd.index};
   assign cmd_wide = {{IDX_W{1'b0}}, cmd_ff.index};
   assign q_addr   = q_wide[IDX_W-1:0];
   assign cmd_addr = cmd_wide[IDX_W-1:0];
   assign id_wide  = {{GROUP_W{1'b0}}, rpt_idx_ff} + (IDX_W+GROUP_W)'(1);

   // entry as read; an entry never written since the last clear reads as zero
   assign ent_cnt   = rd_valid_ff ? rd_cnt_ff : '0;
   assign ent_sum   = rd_valid_ff ? rd_sum_ff : '0;
   assign ent_min   = rd_valid_ff ? rd_min_ff : '0;
   assign ent_max   = rd_valid_ff ? rd_max_ff : '0;
   assign ent_empty = (ent_cnt == '0);
   assign cnt_sat   = (ent_cnt == '1);

   // entry update; the sum cannot leave its range since the count saturates
   always_comb begin
      new_min = (ent_empty || (cmd_ff.temperature < ent_min)) ? cmd_ff.temperature : ent_min;
      new_max = (ent_empty || (cmd_ff.temperature > ent_max)) ? cmd_ff.temperature : ent_max;
      new_cnt = cnt_sat ? ent_cnt : ent_cnt + 1'b1;
      new_sum = cnt_sat ? ent_sum : ent_sum + SUM_BITS'(cmd_ff.temperature);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer: next state and controls
   always_comb begin
      state_in   = state_ff;
      rpt_idx_in = rpt_idx_ff;
      q_pop      = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = rpt_idx_ff;
      wr_en      = 1'b0;
      clr_valid  = 1'b0;
      tot_clr    = 1'b0;
      tot_acc    = 1'b0;
      div_start  = 1'b0;
      div_num    = TSUM_W'(ent_sum);
      div_den    = TCNT_W'(ent_cnt);
      load_grp   = 1'b0;
      load_tot   = 1'b0;
      unique case (state_ff)
         ST_FETCH: begin
            rd_addr = q_addr;
            if (q_valid) begin
               q_pop    = 1'b1;
               rd_en    = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            wr_en = cmd_ff.hit;
            if (cmd_ff.is_last) begin
               tot_clr    = 1'b1;
               rpt_idx_in = '0;
               state_in   = ST_RPT_READ;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_RPT_READ: begin
            rd_en    = 1'b1;
            state_in = ST_RPT_START;
         end
         ST_RPT_START: begin
            tot_acc   = 1'b1;
            div_start = 1'b1;
            state_in  = ST_RPT_WAIT;
         end
         ST_RPT_WAIT: begin
            if (!div_busy && out_free) begin
               load_grp = 1'b1;
               if (rpt_idx_ff == IDX_W'(NUM_GROUPS - 1)) begin
                  state_in = ST_TOT_START;
               end else begin
                  rpt_idx_in = rpt_idx_ff + 1'b1;
                  state_in   = ST_RPT_READ;
               end
            end
         end
         ST_TOT_START: begin
            div_num   = tot_sum_ff;
            div_den   = tot_cnt_ff;
            div_start = 1'b1;
            state_in  = ST_TOT_WAIT;
         end
         ST_TOT_WAIT: begin
            if (!div_busy && out_free) begin
               load_tot  = 1'b1;
               clr_valid = 1'b1;
               state_in  = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FETCH;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rpt_idx_ff <= rpt_idx_in;
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end
   end

   // store memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[cmd_addr] <= new_cnt;
         sum_mem[cmd_addr] <= new_sum;
         min_mem[cmd_addr] <= new_min;
         max_mem[cmd_addr] <= new_max;
      end
      if (rd_en) begin
         rd_cnt_ff   <= cnt_mem[rd_addr];
         rd_sum_ff   <= sum_mem[rd_addr];
         rd_min_ff   <= min_mem[rd_addr];
         rd_max_ff   <= max_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // entry valid bits, cleared at once after each report
   always_ff @(posedge clock) begin
      if (reset || clr_valid) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[cmd_addr] <= 1'b1;
      end
   end

   // totals over the report; min and max only over non-empty groups
   always_ff @(posedge clock) begin
      if (reset || tot_clr) begin
         tot_cnt_ff <= '0;
         tot_sum_ff <= '0;
         tot_min_ff <= '0;
         tot_max_ff <= '0;
         seen_ff    <= 1'b0;
      end else if (tot_acc) begin
         tot_cnt_ff <= tot_cnt_ff + TCNT_W'(ent_cnt);
         tot_sum_ff <= tot_sum_ff + TSUM_W'(ent_sum);
         if (!ent_empty) begin
            if (!seen_ff || (ent_min < tot_min_ff)) begin
               tot_min_ff <= ent_min;
            end
            if (!seen_ff || (ent_max > tot_max_ff)) begin
               tot_max_ff <= ent_max;
            end
            seen_ff <= 1'b1;
         end
      end
   end

   gmms_div #(
      .NUM_W (TSUM_W),
      .DEN_W (TCNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_grp || load_tot) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_grp) begin
         rsp_group_ff <= id_wide[GROUP_W-1:0];
         rsp_count_ff <= ent_cnt;
         rsp_min_ff   <= ent_min;
         rsp_max_ff   <= ent_max;
         rsp_mean_ff  <= ent_empty ? '0 : div_q;
         rsp_last_ff  <= 1'b0;
      end else if (load_tot) begin
         rsp_group_ff <= '0;
         rsp_count_ff <= (|tot_cnt_ff[TCNT_W-1:COUNT_BITS]) ? '1
                                                              : tot_cnt_ff[COUNT_BITS-1:0];
         rsp_min_ff   <= tot_min_ff;
         rsp_max_ff   <= tot_max_ff;
         rsp_mean_ff  <= (tot_cnt_ff == '0) ? '0 : div_q;
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_group_id     = rsp_group_ff;
   assign rsp_record_count = rsp_count_ff;
   assign rsp_min_value    = rsp_min_ff;
   assign rsp_max_value    = rsp_max_ff;
   assign rsp_mean_value   = rsp_mean_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule

`default_nettype wire

/* rtl/core/grouped_min_max_mean_stats.sv */
// top level of the grouped min/max/mean statistics block
// depends on gmms_pkg, gmms_front and gmms_back
`default_nettype none

// Records (group, signed temperature, last flag) enter through a two-entry
// queue and are applied to a per-group store of count, sum, minimum and
// maximum; groups outside 1..NUM_GROUPS are dropped. Each record passes
// through the back end in ST_FETCH, which reads its group entry from the
// store memory, and ST_UPDATE, which writes it back; a new record is taken
// from the queue only once the last one is written back. A record flagged
// last is applied first and then starts the report: for every group one
// read, one start of the mean divider, a wait for the divider and the
// result register, and one load of the result register; then one start,
// wait and load for the total. With no back pressure on the result side,
// the divider, one quotient bit a cycle, sets the length of each wait.
// The store reads as empty after reset and after each report, with no
// clearing pass. The total result carries group 0 and last_result high.
module grouped_min_max_mean_stats #(
   parameter int NUM_GROUPS = 12,
   parameter int COUNT_BITS = 20
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [gmms_pkg::GROUP_W-1:0]        req_group,
   input  wire logic signed [gmms_pkg::TEMP_W-1:0]  req_temperature,
   input  wire logic                                req_is_last,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [gmms_pkg::GROUP_W-1:0]             rsp_group_id,
   output logic [COUNT_BITS-1:0]                    rsp_record_count,
   output logic signed [gmms_pkg::TEMP_W-1:0]       rsp_min_value,
   output logic signed [gmms_pkg::TEMP_W-1:0]       rsp_max_value,
   output logic signed [gmms_pkg::MEAN_BITS-1:0]    rsp_mean_value,
   output logic                                     rsp_last_result
);
   import gmms_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   // accept and classify
   gmms_front #(
      .NUM_GROUPS (NUM_GROUPS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_group       (req_group),
      .req_temperature (req_temperature),
      .req_is_last     (req_is_last),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop)
   );

   // store update and report
   gmms_back #(
      .NUM_GROUPS (NUM_GROUPS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_group_id     (rsp_group_id),
      .rsp_record_count (rsp_record_count),
      .rsp_min_value    (rsp_min_value),
      .rsp_max_value    (rsp_max_value),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_last_result  (rsp_last_result)
   );

   // back end never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // queue only drains through a pop
   a_drain_by_pop: assert property (@(posedge clock) disable iff (reset)
      $fell(q_valid) |-> $past(q_pop))
      else $error("queue lost a transaction");

   // the total result is group zero
   a_total_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |-> (rsp_group_id == '0))
      else $error("total result with nonzero group");

   // minimum never exceeds maximum in any result
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_min_value <= rsp_max_value))
      else $error("result minimum above maximum");

endmodule

`default_nettype wire
